// ----- hw/rtl/sip_header_classifier_macros.svh -----
// Assertion macros for the SIP header classifier.
`ifndef SIP_HEADER_CLASSIFIER_MACROS_SVH
`define SIP_HEADER_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS
`define SHC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shc assertion failed");
`define SHC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shc assertion failed");
`else
`define SHC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SHC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/shc_pkg.sv -----
package shc_pkg;

    localparam logic [7:0] LF_BYTE    = 8'h0A;
    localparam logic [7:0] DIGIT_LO   = 8'h30;
    localparam logic [7:0] DIGIT_HI   = 8'h39;
    localparam logic [9:0] CODE_MAX   = 10'd999;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_REQ   = 2'd1;
    localparam logic [1:0] KIND_RESP  = 2'd2;

    localparam logic [3:0] INVI_LEN   = 4'd4;
    localparam logic [3:0] RESP_LEN   = 4'd8;
    localparam logic [2:0] CSEQ_LEN   = 3'd6;
    localparam logic [2:0] METH_LEN   = 3'd6;

    typedef enum logic [2:0] {
        PH_START,
        PH_INVI,
        PH_SIPV,
        PH_CODE,
        PH_BODY,
        PH_HDR,
        PH_SEQ,
        PH_METH
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        invite;
        logic [31:0] cseq;
        logic [9:0]  status;
    } shc_result_t;

    // "INVI"
    function automatic logic [7:0] invi_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = 8'h49;
            2'd1: b = 8'h4E;
            2'd2: b = 8'h56;
            default: b = 8'h49;
        endcase
        return b;
    endfunction

    // "SIP/2.0 "
    function automatic logic [7:0] resp_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0: b = 8'h53;
            3'd1: b = 8'h49;
            3'd2: b = 8'h50;
            3'd3: b = 8'h2F;
            3'd4: b = 8'h32;
            3'd5: b = 8'h2E;
            3'd6: b = 8'h30;
            default: b = 8'h20;
        endcase
        return b;
    endfunction

    // "CSeq: "
    function automatic logic [7:0] cseq_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0: b = 8'h43;
            3'd1: b = 8'h53;
            3'd2: b = 8'h65;
            3'd3: b = 8'h71;
            3'd4: b = 8'h3A;
            3'd5: b = 8'h20;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // "INVITE"
    function automatic logic [7:0] meth_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0: b = 8'h49;
            3'd1: b = 8'h4E;
            3'd2: b = 8'h56;
            3'd3: b = 8'h49;
            3'd4: b = 8'h54;
            3'd5: b = 8'h45;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- hw/rtl/shc_parser.sv -----
module shc_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_message,
    output shc_pkg::shc_result_t result
);

    shc_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  offset_reg, offset_next;
    logic [2:0]  match_reg, match_next;
    logic [31:0] seq_reg, seq_next;
    logic [9:0]  code_reg, code_next;
    logic [1:0]  kind_reg, kind_next;
    logic        invite_reg, invite_next;
    logic        line_start_reg, line_start_next;

    logic        is_digit;
    logic        do_body;
    logic [3:0]  digit;
    logic [35:0] seq_mac;
    logic [13:0] code_mac;
    logic [31:0] seq_sat;
    logic [9:0]  code_sat;

    assign is_digit = (data_byte >= shc_pkg::DIGIT_LO) && (data_byte <= shc_pkg::DIGIT_HI);
    assign digit    = data_byte[3:0];

    // x*10 + d as shifts and adds
    assign seq_mac  = {1'b0, seq_reg, 3'b000} + {3'b000, seq_reg, 1'b0} + {32'd0, digit};
    assign seq_sat  = (seq_mac[35:32] != 4'd0) ? 32'hFFFF_FFFF : seq_mac[31:0];
    assign code_mac = {1'b0, code_reg, 3'b000} + {3'b000, code_reg, 1'b0} + {10'd0, digit};
    assign code_sat = (code_mac > {4'd0, shc_pkg::CODE_MAX}) ? shc_pkg::CODE_MAX
                                                           : code_mac[9:0];

    always_comb begin
        phase_next      = phase_reg;
        offset_next     = offset_reg;
        match_next      = match_reg;
        seq_next        = seq_reg;
        code_next       = code_reg;
        kind_next       = kind_reg;
        invite_next     = invite_reg;
        line_start_next = line_start_reg;
        do_body         = 1'b0;

        unique case (phase_reg)
            shc_pkg::PH_START: begin
                offset_next = 4'd1;
                if (data_byte == shc_pkg::invi_byte(2'd0)) begin
                    phase_next = shc_pkg::PH_INVI;
                end else if (data_byte == shc_pkg::resp_byte(3'd0)) begin
                    phase_next = shc_pkg::PH_SIPV;
                end else begin
                    do_body = 1'b1;
                end
            end
            shc_pkg::PH_INVI: begin
                if (offset_reg < shc_pkg::INVI_LEN &&
                    data_byte == shc_pkg::invi_byte(offset_reg[1:0])) begin
                    offset_next = offset_reg + 4'd1;
                    if (offset_next == shc_pkg::INVI_LEN) begin
                        kind_next   = shc_pkg::KIND_REQ;
                        invite_next = 1'b1;
                        phase_next  = shc_pkg::PH_BODY;
                    end
                end else begin
                    do_body = 1'b1;
                end
            end
            shc_pkg::PH_SIPV: begin
                if (offset_reg < shc_pkg::RESP_LEN &&
                    data_byte == shc_pkg::resp_byte(offset_reg[2:0])) begin
                    offset_next = offset_reg + 4'd1;
                    if (offset_next == shc_pkg::RESP_LEN) begin
                        kind_next  = shc_pkg::KIND_RESP;
                        code_next  = 10'd0;
                        phase_next = shc_pkg::PH_CODE;
                    end
                end else begin
                    do_body = 1'b1;
                end
            end
            shc_pkg::PH_CODE: begin
                if (is_digit) begin
                    code_next = code_sat;
                end else begin
                    do_body = 1'b1;
                end
            end
            shc_pkg::PH_HDR: begin
                if (match_reg < shc_pkg::CSEQ_LEN &&
                    data_byte == shc_pkg::cseq_byte(match_reg)) begin
                    match_next = match_reg + 3'd1;
                    if (match_next == shc_pkg::CSEQ_LEN) begin
                        seq_next   = 32'd0;
                        phase_next = shc_pkg::PH_SEQ;
                    end
                end else begin
                    do_body = 1'b1;
                end
            end
            shc_pkg::PH_SEQ: begin
                if (is_digit) begin
                    seq_next = seq_sat;
                end else if (kind_reg == shc_pkg::KIND_RESP &&
                             data_byte != shc_pkg::LF_BYTE) begin
                    match_next = 3'd0;
                    phase_next = shc_pkg::PH_METH;
                end else begin
                    do_body = 1'b1;
                end
            end
            shc_pkg::PH_METH: begin
                if (match_reg < shc_pkg::METH_LEN &&
                    data_byte == shc_pkg::meth_byte(match_reg)) begin
                    match_next = match_reg + 3'd1;
                    if (match_next == shc_pkg::METH_LEN) begin
                        invite_next = 1'b1;
                        phase_next  = shc_pkg::PH_BODY;
                    end
                end else begin
                    do_body = 1'b1;
                end
            end
            default: begin
                do_body = 1'b1;
            end
        endcase

        // CSeq header search at line starts
        if (do_body) begin
            if (line_start_reg && data_byte == shc_pkg::cseq_byte(3'd0)) begin
                phase_next      = shc_pkg::PH_HDR;
                match_next      = 3'd1;
                line_start_next = 1'b0;
            end else begin
                phase_next      = shc_pkg::PH_BODY;
                line_start_next = (data_byte == shc_pkg::LF_BYTE);
            end
        end
    end

    always_comb begin
        result.kind   = kind_next;
        result.invite = invite_next;
        result.cseq   = seq_next;
        result.status = (kind_next == shc_pkg::KIND_RESP) ? code_next : 10'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && end_of_message)) begin
            phase_reg      <= shc_pkg::PH_START;
            offset_reg     <= 4'd0;
            match_reg      <= 3'd0;
            seq_reg        <= 32'd0;
            code_reg       <= 10'd0;
            kind_reg       <= shc_pkg::KIND_NONE;
            invite_reg     <= 1'b0;
            line_start_reg <= 1'b0;
        end else if (step) begin
            phase_reg      <= phase_next;
            offset_reg     <= offset_next;
            match_reg      <= match_next;
            seq_reg        <= seq_next;
            code_reg       <= code_next;
            kind_reg       <= kind_next;
            invite_reg     <= invite_next;
            line_start_reg <= line_start_next;
        end
    end

endmodule

// ----- hw/rtl/sip_header_classifier.sv -----
// Channel   Dir  tdata                                         tuser     tlast
// s_        in   [7:0] data_byte                               -         end_of_message
// m_        out  [0] is_invite [32:1] cseq [42:33] status      msg_kind  -
//
// One byte word per cycle, sustained while no last byte is held. Input register, parse logic,
// output register: a result is registered as its last byte advances out of the input register.
// A last byte waits in the input register, holding off s_tready, while a stalled result
// occupies the output register; no other byte ever stalls.
// aresetn is synchronous, active low; parse state returns to start after every result.
`include "sip_header_classifier_macros.svh"

module sip_header_classifier (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [0] is_invite, [32:1] cseq_number, [42:33] status_code
    output logic [1:0]  m_tuser    // [1:0] msg_kind
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;
    logic                 m_valid_reg, m_valid_next;
    shc_pkg::shc_result_t m_result_reg;
    shc_pkg::shc_result_t result;
    logic                 out_free;
    logic                 advance;

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    shc_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (advance),
        .data_byte      (in_byte_reg),
        .end_of_message (in_last_reg),
        .result         (result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance && in_last_reg) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            m_result_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_result_reg.kind;
    assign m_tdata  = {5'd0, m_result_reg.status, m_result_reg.cseq, m_result_reg.invite};

    `SHC_ASSERT_IMP(a_kind_range, aclk, aresetn, m_tvalid, m_tuser != 2'd3)
    `SHC_ASSERT_IMP(a_status_resp_only, aclk, aresetn,
        m_tvalid && m_tuser != shc_pkg::KIND_RESP, m_tdata[42:33] == 10'd0)
    `SHC_ASSERT_IMP(a_invite_has_kind, aclk, aresetn,
        m_tvalid && m_tdata[0], m_tuser != shc_pkg::KIND_NONE)
    `SHC_ASSERT_NXT(a_stalled_result_held, aclk, aresetn,
        m_valid_reg && !m_tready, m_valid_reg && $stable(m_result_reg))

endmodule
